[src/text_mode_glyph_renderer_defines.svh]
// Assertion macros used by the glyph renderer sequencer.
`ifndef TEXT_MODE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_MODE_GLYPH_RENDERER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMGR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glyph renderer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glyph renderer check failed");

`endif

[src/tmgr_pkg.sv]
`default_nettype none

package tmgr_pkg;

  localparam int GLYPH_LINES_DEF = 16;
  localparam int SCREEN_ROWS_DEF = 25;
  localparam int SCREEN_COLS_DEF = 80;

  localparam int GLYPH_DEPTH  = 4096;
  localparam int GLYPH_ADDR_W = 12;
  localparam int FONT_W       = 8;
  localparam int CODE_W       = 8;
  localparam int ROW_W        = 4;
  localparam int COLOUR_W     = 6;
  localparam int PIX_W        = 48;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;

  localparam logic [2:0] REG_BLINK_EN   = 3'd0;
  localparam logic [2:0] REG_BLINK_PH   = 3'd1;
  localparam logic [2:0] REG_CUR_START  = 3'd2;
  localparam logic [2:0] REG_CUR_END    = 3'd3;
  localparam logic [2:0] REG_CUR_ROW    = 3'd4;
  localparam logic [2:0] REG_CUR_COL    = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic       blink_enable;
    logic       blink_phase;
    logic [4:0] cursor_start;
    logic [4:0] cursor_end;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
  } cfg_t;

  typedef struct packed {
    logic                vld;
    logic [ROW_W-1:0]    row;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
    logic                on_cursor;
  } row_ctl_t;

  function automatic logic [COLOUR_W-1:0] colour_of(input logic [3:0] idx);
    logic [COLOUR_W-1:0] c;
    case (idx)
      4'd0:    c = 6'h00;
      4'd1:    c = 6'h01;
      4'd2:    c = 6'h02;
      4'd3:    c = 6'h03;
      4'd4:    c = 6'h04;
      4'd5:    c = 6'h05;
      4'd6:    c = 6'h06;
      4'd7:    c = 6'h07;
      4'd8:    c = 6'h38;
      4'd9:    c = 6'h09;
      4'd10:   c = 6'h12;
      4'd11:   c = 6'h1B;
      4'd12:   c = 6'h24;
      4'd13:   c = 6'h2D;
      4'd14:   c = 6'h36;
      default: c = 6'h3F;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/tmgr_ram.sv]
`default_nettype none

module tmgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/tmgr_regs.sv]
`default_nettype none

module tmgr_regs
  import tmgr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_enable <= 1'b0;
      cfg_q.blink_phase  <= 1'b1;
      cfg_q.cursor_start <= 5'd14;
      cfg_q.cursor_end   <= 5'd15;
      cfg_q.cursor_row   <= 8'd255;
      cfg_q.cursor_col   <= 8'd255;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BLINK_EN:  cfg_q.blink_enable <= pwdata[0];
        REG_BLINK_PH:  cfg_q.blink_phase  <= pwdata[0];
        REG_CUR_START: cfg_q.cursor_start <= pwdata[4:0];
        REG_CUR_END:   cfg_q.cursor_end   <= pwdata[4:0];
        REG_CUR_ROW:   cfg_q.cursor_row   <= pwdata[7:0];
        REG_CUR_COL:   cfg_q.cursor_col   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLINK_EN:  prdata = {31'd0, cfg_q.blink_enable};
      REG_BLINK_PH:  prdata = {31'd0, cfg_q.blink_phase};
      REG_CUR_START: prdata = {27'd0, cfg_q.cursor_start};
      REG_CUR_END:   prdata = {27'd0, cfg_q.cursor_end};
      REG_CUR_ROW:   prdata = {24'd0, cfg_q.cursor_row};
      REG_CUR_COL:   prdata = {24'd0, cfg_q.cursor_col};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/tmgr_seq.sv]
`default_nettype none

`include "text_mode_glyph_renderer_defines.svh"

module tmgr_seq
  import tmgr_pkg::*;
#(
  parameter int GLYPH_LINES = GLYPH_LINES_DEF,
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    req_type_i,
  input  wire logic [CODE_W-1:0]       char_code_i,
  input  wire logic [7:0]              attr_i,
  input  wire logic [4:0]              cell_row_i,
  input  wire logic [6:0]              cell_col_i,
  input  wire cfg_t                    cfg_i,
  output logic                         busy_o,
  output logic                         ram_we_o,
  output logic                         ram_re_o,
  output logic [GLYPH_ADDR_W-1:0]      ram_raddr_o,
  output row_ctl_t                     ctl_o
);

  localparam logic [ROW_W-1:0] LastRow = ROW_W'(GLYPH_LINES - 1);
  localparam logic [4:0]       FhLim   = 5'(GLYPH_LINES);
  localparam logic [7:0]       RowLim  = 8'(SCREEN_ROWS);
  localparam logic [7:0]       ColLim  = 8'(SCREEN_COLS);

  seq_state_e          state_q, state_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                rd_vld_q;
  logic [ROW_W-1:0]    rd_row_q;
  logic [CODE_W-1:0]   code_q;
  logic [COLOUR_W-1:0] fg_q, bg_q;
  logic                cur_q;

  logic                accept;
  logic                render_go;
  logic [7:0]          attr_eff;
  logic                on_cursor;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign render_go = accept && req_type_i;
  assign busy_o    = (state_q != ST_IDLE);
  assign ram_we_o  = accept && !req_type_i;

  // A blinking cell in the off phase takes its background nibble as foreground.
  always_comb begin
    attr_eff = attr_i;
    if (cfg_i.blink_enable) begin
      attr_eff[7] = 1'b0;
      if (!cfg_i.blink_phase && attr_i[7]) begin
        attr_eff = {1'b0, attr_i[6:4], 1'b0, attr_i[6:4]};
      end
    end
  end

  assign on_cursor = (cfg_i.cursor_start <= cfg_i.cursor_end)
                  && (cfg_i.cursor_start < FhLim)
                  && (cfg_i.cursor_row < RowLim)
                  && (cfg_i.cursor_col < ColLim)
                  && ({3'd0, cell_row_i} == cfg_i.cursor_row)
                  && ({1'b0, cell_col_i} == cfg_i.cursor_col);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    case (state_q)
      ST_IDLE: begin
        if (render_go) begin
          state_d = ST_READ;
          row_d   = '0;
        end
      end
      ST_READ: begin
        row_d = row_q + 1'b1;
        if (row_q == LastRow) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      row_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_row_q <= '0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      rd_vld_q <= ram_re_o;
      rd_row_q <= row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_go) begin
      code_q <= char_code_i;
      fg_q   <= colour_of(attr_eff[3:0]);
      bg_q   <= colour_of(attr_eff[7:4]);
      cur_q  <= on_cursor;
    end
  end

  assign ram_re_o    = (state_q == ST_READ);
  assign ram_raddr_o = {code_q, row_q};

  assign ctl_o.vld       = rd_vld_q;
  assign ctl_o.row       = rd_row_q;
  assign ctl_o.fg        = fg_q;
  assign ctl_o.bg        = bg_q;
  assign ctl_o.on_cursor = cur_q;

  `TMGR_ASSERT_NEXT(a_render_starts, render_go, (state_q == ST_READ) && (row_q == '0))
  `TMGR_ASSERT_NEXT(a_last_read_drains, (state_q == ST_READ) && (row_q == LastRow), state_q == ST_DRAIN)
  `TMGR_ASSERT_NEXT(a_drain_ends, state_q == ST_DRAIN, (state_q == ST_IDLE) && !rd_vld_q)
  `TMGR_ASSERT_SAME(a_data_in_item, rd_vld_q, (state_q == ST_READ) || (state_q == ST_DRAIN))

endmodule

`default_nettype wire

[src/tmgr_pix.sv]
`default_nettype none

module tmgr_pix
  import tmgr_pkg::*;
#(
  parameter int GLYPH_LINES = GLYPH_LINES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire row_ctl_t          ctl_i,
  input  wire cfg_t              cfg_i,
  input  wire logic [FONT_W-1:0] bits_i,
  output logic                   row_valid_o,
  output logic [ROW_W-1:0]       glyph_row_o,
  output logic [PIX_W-1:0]       pixels_o,
  output logic                   last_row_o
);

  localparam logic [ROW_W-1:0] LastRow = ROW_W'(GLYPH_LINES - 1);

  logic                valid_q;
  logic [ROW_W-1:0]    row_q;
  logic [PIX_W-1:0]    pix_q;
  logic                last_q;
  logic                in_cursor;
  logic [COLOUR_W-1:0] fg_use, bg_use;
  logic [PIX_W-1:0]    pix_d;

  // Rows of the cursor are drawn with the two colours swapped.
  assign in_cursor = ctl_i.on_cursor
                  && ({1'b0, ctl_i.row} >= cfg_i.cursor_start)
                  && ({1'b0, ctl_i.row} <= cfg_i.cursor_end);
  assign fg_use = in_cursor ? ctl_i.bg : ctl_i.fg;
  assign bg_use = in_cursor ? ctl_i.fg : ctl_i.bg;

  always_comb begin
    for (int p = 0; p < FONT_W; p++) begin
      pix_d[p*COLOUR_W +: COLOUR_W] = bits_i[p] ? fg_use : bg_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      row_q  <= ctl_i.row;
      pix_q  <= pix_d;
      last_q <= (ctl_i.row == LastRow);
    end
  end

  assign row_valid_o = valid_q;
  assign glyph_row_o = row_q;
  assign pixels_o    = pix_q;
  assign last_row_o  = last_q;

endmodule

`default_nettype wire

[src/text_mode_glyph_renderer.sv]
// Text-mode glyph renderer. A load request writes one font byte into the 4096-entry glyph
// store at the edge it is taken and leaves busy_o low, so another request may follow on the
// next cycle. A render request holds busy_o high through its read and drain states: in the
// read state the sequencer reads one glyph row per cycle from the single read port of the
// store, and the drain state lets the last row leave the read pipeline before the colours of
// a new request are captured. Each row is on the outputs for exactly one cycle with row_valid_o
// high; the first passes the state, read data and pixel registers in turn, and the last is in
// the first cycle with busy_o low again. The receiver cannot stall and must take every row as
// it appears. The glyph store is not cleared after reset: a glyph must be loaded before it is
// rendered. Configuration registers should be written only while no rows are still owed.
`default_nettype none

module text_mode_glyph_renderer
  import tmgr_pkg::*;
#(
  parameter int GLYPH_LINES = GLYPH_LINES_DEF,
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    req_type_i,
  input  wire logic [GLYPH_ADDR_W-1:0] font_addr_i,
  input  wire logic [FONT_W-1:0]       font_byte_i,
  input  wire logic [CODE_W-1:0]       char_code_i,
  input  wire logic [7:0]              attr_i,
  input  wire logic [4:0]              cell_row_i,
  input  wire logic [6:0]              cell_col_i,
  output logic                         row_valid_o,
  output logic [ROW_W-1:0]             glyph_row_o,
  output logic [PIX_W-1:0]             pixels_o,
  output logic                         last_row_o,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [PADDR_W-1:0]      paddr,
  input  wire logic [PDATA_W-1:0]      pwdata,
  output logic      [PDATA_W-1:0]      prdata,
  output logic                         pready
);

  cfg_t                    cfg;
  row_ctl_t                ctl;
  logic                    ram_we;
  logic                    ram_re;
  logic [GLYPH_ADDR_W-1:0] ram_raddr;
  logic [FONT_W-1:0]       ram_rdata;

  tmgr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmgr_seq #(
    .GLYPH_LINES (GLYPH_LINES),
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .attr_i      (attr_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .cfg_i       (cfg),
    .busy_o      (busy_o),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ctl_o       (ctl)
  );

  tmgr_ram #(
    .WIDTH (FONT_W),
    .DEPTH (GLYPH_DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (font_addr_i),
    .wdata_i (font_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tmgr_pix #(
    .GLYPH_LINES (GLYPH_LINES)
  ) u_pix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_i       (cfg),
    .bits_i      (ram_rdata),
    .row_valid_o (row_valid_o),
    .glyph_row_o (glyph_row_o),
    .pixels_o    (pixels_o),
    .last_row_o  (last_row_o)
  );

endmodule

`default_nettype wire

[dv/text_mode_glyph_renderer_tb.sv]
`timescale 1ns / 100ps

module text_mode_glyph_renderer_tb
  import tmgr_pkg::*;
();

  localparam int FH = GLYPH_LINES_DEF;
  localparam int N_DIR = 41;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_RENDER = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RENDER,
    OP_CFG
  } step_op_e;

  typedef struct {
    req_kind_e   kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  code;
    logic [7:0]  attr;
    logic [4:0]  crow;
    logic [6:0]  ccol;
  } req_t;

  typedef struct {
    step_op_e         op;
    logic [11:0]      addr;
    logic [7:0]       data;
    logic [7:0]       code;
    logic [7:0]       attr;
    logic [4:0]       crow;
    logic [6:0]       ccol;
    logic [2:0]       reg_idx;
    logic [7:0]       reg_val;
    bit               typed;
    logic [PIX_W-1:0] typed_pix;
  } step_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pix;
    logic             last;
  } row_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    req_type_i;
  logic [GLYPH_ADDR_W-1:0] font_addr_i;
  logic [FONT_W-1:0]       font_byte_i;
  logic [CODE_W-1:0]       char_code_i;
  logic [7:0]              attr_i;
  logic [4:0]              cell_row_i;
  logic [6:0]              cell_col_i;
  logic                    row_valid_o;
  logic [ROW_W-1:0]        glyph_row_o;
  logic [PIX_W-1:0]        pixels_o;
  logic                    last_row_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  logic [5:0] palette [16] = '{6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h06, 6'h07,
                               6'h38, 6'h09, 6'h12, 6'h1B, 6'h24, 6'h2D, 6'h36, 6'h3F};

  logic [7:0] font_shadow [GLYPH_DEPTH];
  bit         written_rows [GLYPH_DEPTH];
  bit         usable [256];
  logic [7:0] loaded_codes [$];
  row_res_t   pending_rows [$];
  cfg_t       regs_shadow;
  int         mismatches = 0;
  int         n_loads = 0;
  int         n_renders = 0;
  int         n_rows = 0;
  int         n_settings = 0;
  int         idle_plan [5] = '{0, 66, 16, 66, 0};

  // Renders of glyphs 8'h00 (all rows clear) and 8'hFF (all rows set) have
  // uniform rows, so their pixels can be written down directly.
  step_t dir_tab [N_DIR] = '{
    '{OP_RENDER, 12'h000, 8'h00, 8'hFF, 8'h0F, 5'd0,  7'd0,   REG_BLINK_EN, 8'd0, 1'b1,
      48'hFFFF_FFFF_FFFF},
    '{OP_RENDER, 12'h000, 8'h00, 8'hFF, 8'hF0, 5'd24, 7'd79,  REG_BLINK_EN, 8'd0, 1'b1,
      48'h0000_0000_0000},
    '{OP_RENDER, 12'h000, 8'h00, 8'h00, 8'h80, 5'd31, 7'd127, REG_BLINK_EN, 8'd0, 1'b1,
      48'hE38E_38E3_8E38},
    '{OP_RENDER, 12'h000, 8'h00, 8'h00, 8'h7F, 5'd0,  7'd79,  REG_BLINK_EN, 8'd0, 1'b1,
      48'h1C71_C71C_71C7},
    '{OP_LOAD,   12'h5AF, 8'h81, 8'hFF, 8'hFF, 5'd31, 7'd127, REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_RENDER, 12'hFFF, 8'hFF, 8'h5A, 8'h1E, 5'd3,  7'd7,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hA5, 8'hC3, 5'd12, 7'd40,  REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_BLINK_EN, 8'd1, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hA5, 8'h8F, 5'd1,  7'd1,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'h5A, 8'hFF, 5'd2,  7'd2,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_BLINK_PH, 8'd0, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hFF, 8'h9E, 5'd5,  7'd5,   REG_BLINK_EN, 8'd0, 1'b1,
      48'h0410_4104_1041},
    '{OP_RENDER, 12'h000, 8'h00, 8'hA5, 8'h1E, 5'd6,  7'd6,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'h5A, 8'hF7, 5'd6,  7'd6,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_ROW,  8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_COL,  8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_START, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_END, 8'd31, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hA5, 8'h8C, 5'd0,  7'd0,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hFF, 8'h4A, 5'd0,  7'd1,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_BLINK_PH, 8'd1, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_ROW, 8'd24, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_COL, 8'd79, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_START, 8'd5, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_END,  8'd9, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'h5A, 8'hF1, 5'd24, 7'd79,  REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_END, 8'd31, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_START, 8'd16, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hFF, 8'h2B, 5'd24, 7'd79,  REG_BLINK_EN, 8'd0, 1'b1,
      48'h6DB6_DB6D_B6DB},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_START, 8'd9, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_END,  8'd5, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hA5, 8'h2B, 5'd24, 7'd79,  REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_START, 8'd15, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_END, 8'd15, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hA5, 8'h2B, 5'd24, 7'd79,  REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_ROW, 8'd25, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'hA5, 8'hD4, 5'd25, 7'd79,  REG_BLINK_EN, 8'd0, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_ROW, 8'd255, 1'b0, '0},
    '{OP_CFG,    12'h000, 8'h00, 8'h00, 8'h00, 5'd0,  7'd0,   REG_CUR_COL, 8'd255, 1'b0, '0},
    '{OP_RENDER, 12'h000, 8'h00, 8'h5A, 8'h00, 5'd24, 7'd0,   REG_BLINK_EN, 8'd0, 1'b0, '0}
  };

  text_mode_glyph_renderer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .font_addr_i (font_addr_i),
    .font_byte_i (font_byte_i),
    .char_code_i (char_code_i),
    .attr_i      (attr_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .row_valid_o (row_valid_o),
    .glyph_row_o (glyph_row_o),
    .pixels_o    (pixels_o),
    .last_row_o  (last_row_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH at %0t: %s, got %0h, wanted %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [PIX_W-1:0] paint_row(input logic [7:0] bits,
                                                 input logic [5:0] ink,
                                                 input logic [5:0] paper);
    logic [PIX_W-1:0] acc;
    for (int p = 0; p < 8; p++) acc[PIX_W-1-6*p -: 6] = bits[7-p] ? ink : paper;
    return acc;
  endfunction

  task automatic paint_cell(input req_t rq);
    logic [7:0] a;
    logic [5:0] fg;
    logic [5:0] bg;
    bit         hit;
    bit         cur;
    row_res_t   e;
    a = rq.attr;
    if (regs_shadow.blink_enable) begin
      if (!regs_shadow.blink_phase && a[7]) a = {1'b0, a[6:4], 1'b0, a[6:4]};
      else a[7] = 1'b0;
    end
    fg = palette[a[3:0]];
    bg = palette[a[7:4]];
    hit = regs_shadow.cursor_start <= regs_shadow.cursor_end &&
          regs_shadow.cursor_start < FH &&
          regs_shadow.cursor_row < SCREEN_ROWS_DEF &&
          regs_shadow.cursor_col < SCREEN_COLS_DEF &&
          {3'b000, rq.crow} == regs_shadow.cursor_row &&
          {1'b0, rq.ccol} == regs_shadow.cursor_col;
    for (int r = 0; r < FH; r++) begin
      cur = hit && r >= regs_shadow.cursor_start && r <= regs_shadow.cursor_end;
      e.row = r[3:0];
      e.pix = cur ? paint_row(font_shadow[{rq.code, r[3:0]}], bg, fg)
                  : paint_row(font_shadow[{rq.code, r[3:0]}], fg, bg);
      e.last = (r == FH - 1);
      pending_rows.push_back(e);
    end
  endtask

  function automatic logic [31:0] field_mask(input logic [2:0] idx);
    case (idx)
      REG_BLINK_EN, REG_BLINK_PH: return 32'h1;
      REG_CUR_START, REG_CUR_END: return 32'h1F;
      default:                    return 32'hFF;
    endcase
  endfunction

  function automatic logic [31:0] shadow_value(input logic [2:0] idx);
    case (idx)
      REG_BLINK_EN:  return {31'b0, regs_shadow.blink_enable};
      REG_BLINK_PH:  return {31'b0, regs_shadow.blink_phase};
      REG_CUR_START: return {27'b0, regs_shadow.cursor_start};
      REG_CUR_END:   return {27'b0, regs_shadow.cursor_end};
      REG_CUR_ROW:   return {24'b0, regs_shadow.cursor_row};
      default:       return {24'b0, regs_shadow.cursor_col};
    endcase
  endfunction

  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== shadow_value(idx)) begin
      note_mismatch("register readback", 64'(rd), 64'(shadow_value(idx)));
    end
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [7:0] val);
    logic [31:0] wd;
    logic [31:0] rd;
    wd = ($urandom() & ~field_mask(idx)) | ({24'b0, val} & field_mask(idx));
    apb_xfer(1'b1, idx, wd, rd);
    case (idx)
      REG_BLINK_EN:  regs_shadow.blink_enable = val[0];
      REG_BLINK_PH:  regs_shadow.blink_phase  = val[0];
      REG_CUR_START: regs_shadow.cursor_start = val[4:0];
      REG_CUR_END:   regs_shadow.cursor_end   = val[4:0];
      REG_CUR_ROW:   regs_shadow.cursor_row   = val;
      default:       regs_shadow.cursor_col   = val;
    endcase
    check_reg(idx);
  endtask

  task automatic issue(input req_t rq, input int gap, input bit typed,
                       input logic [PIX_W-1:0] typed_pix);
    logic [7:0] code;
    bit         full;
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i     <= 1'b1;
    req_type_i  <= rq.kind;
    font_addr_i <= rq.addr;
    font_byte_i <= rq.data;
    char_code_i <= rq.code;
    attr_i      <= rq.attr;
    cell_row_i  <= rq.crow;
    cell_col_i  <= rq.ccol;
    do @(posedge clk_i); while (busy_o);
    if (rq.kind == REQ_LOAD) begin
      n_loads++;
      font_shadow[rq.addr] = rq.data;
      written_rows[rq.addr] = 1'b1;
      code = rq.addr[11:4];
      full = 1'b1;
      for (int r = 0; r < FH; r++) full &= written_rows[{code, r[3:0]}];
      if (full && !usable[code]) begin
        usable[code] = 1'b1;
        loaded_codes.push_back(code);
      end
    end else begin
      n_renders++;
      if (typed) begin
        for (int r = 0; r < FH; r++) pending_rows.push_back('{r[3:0], typed_pix, r == FH - 1});
      end else begin
        paint_cell(rq);
      end
    end
  endtask

  // The block must be quiet before a register is touched.
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic req_t noise_req();
    req_t rq;
    rq.kind = REQ_LOAD;
    rq.addr = 12'($urandom());
    rq.data = 8'($urandom());
    rq.code = 8'($urandom());
    rq.attr = 8'($urandom());
    rq.crow = 5'($urandom());
    rq.ccol = 7'($urandom());
    return rq;
  endfunction

  function automatic int pause(input int pct);
    if ($urandom_range(99) < pct) return $urandom_range(20, 1);
    return 0;
  endfunction

  task automatic shuffle_config();
    logic [4:0] first;
    logic [4:0] final_row;
    logic [7:0] trow;
    logic [7:0] tcol;
    case ($urandom_range(3))
      0:       first = 5'd0;
      1:       first = 5'd31;
      2:       first = 5'($urandom_range(FH - 1));
      default: first = 5'($urandom());
    endcase
    case ($urandom_range(3))
      0:       final_row = first + 5'($urandom_range(3));
      1:       final_row = 5'd31;
      2:       final_row = 5'd0;
      default: final_row = 5'($urandom());
    endcase
    case ($urandom_range(4))
      0:       trow = 8'd0;
      1:       trow = 8'(SCREEN_ROWS_DEF - 1);
      2:       trow = 8'd255;
      3:       trow = 8'($urandom());
      default: trow = 8'($urandom_range(SCREEN_ROWS_DEF - 1));
    endcase
    case ($urandom_range(4))
      0:       tcol = 8'd0;
      1:       tcol = 8'(SCREEN_COLS_DEF - 1);
      2:       tcol = 8'd255;
      3:       tcol = 8'($urandom());
      default: tcol = 8'($urandom_range(SCREEN_COLS_DEF - 1));
    endcase
    program_reg(REG_BLINK_EN, 8'($urandom_range(1)));
    program_reg(REG_BLINK_PH, 8'($urandom_range(1)));
    program_reg(REG_CUR_START, {3'b000, first});
    program_reg(REG_CUR_END, {3'b000, final_row});
    program_reg(REG_CUR_ROW, trow);
    program_reg(REG_CUR_COL, tcol);
    n_settings++;
  endtask

  task automatic run_phase(input int idle_pct, input int quota);
    req_t       rq;
    int         sent;
    int         pick;
    logic [7:0] code;
    sent = 0;
    while (sent < quota) begin
      rq = noise_req();
      pick = $urandom_range(99);
      if (pick < 8) begin
        code = 8'($urandom());
        for (int r = 0; r < FH; r++) begin
          rq = noise_req();
          rq.addr = {code, r[3:0]};
          issue(rq, pause(idle_pct), 1'b0, '0);
        end
        sent += FH;
      end else begin
        if (pick < 20) begin
          rq.addr[11:4] = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
        end else if (pick >= 28) begin
          rq.kind = REQ_RENDER;
          rq.code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
          case ($urandom_range(9))
            0, 1, 2: begin
              rq.crow = regs_shadow.cursor_row[4:0];
              rq.ccol = regs_shadow.cursor_col[6:0];
            end
            3: ;
            default: begin
              rq.crow = 5'($urandom_range(SCREEN_ROWS_DEF - 1));
              rq.ccol = 7'($urandom_range(SCREEN_COLS_DEF - 1));
            end
          endcase
        end
        issue(rq, pause(idle_pct), 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    row_res_t want;
    if (rst_ni === 1'b1 && row_valid_o === 1'b1) begin
      if (pending_rows.size() == 0) begin
        note_mismatch("row with no render request pending", 64'(pixels_o), '0);
      end else begin
        want = pending_rows.pop_front();
        n_rows++;
        if (glyph_row_o !== want.row) begin
          note_mismatch("glyph_row", 64'(glyph_row_o), 64'(want.row));
        end
        if (pixels_o !== want.pix) note_mismatch("pixels", 64'(pixels_o), 64'(want.pix));
        if (last_row_o !== want.last) begin
          note_mismatch("last_row", 64'(last_row_o), 64'(want.last));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    req_t         rq;
    logic [7:0]   seed_codes [4];
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_type_i  = 1'b0;
    font_addr_i = '0;
    font_byte_i = '0;
    char_code_i = '0;
    attr_i      = '0;
    cell_row_i  = '0;
    cell_col_i  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    seed_codes  = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    regs_shadow = '{blink_enable: 1'b0, blink_phase: 1'b1, cursor_start: 5'd14,
                    cursor_end: 5'd15, cursor_row: 8'd255, cursor_col: 8'd255};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = REG_BLINK_EN; i <= REG_CUR_COL; i++) check_reg(i[2:0]);

    foreach (seed_codes[c]) begin
      for (int r = 0; r < FH; r++) begin
        rq = noise_req();
        rq.addr = {seed_codes[c], r[3:0]};
        if (seed_codes[c] == 8'h00) rq.data = 8'h00;
        if (seed_codes[c] == 8'hFF) rq.data = 8'hFF;
        issue(rq, 0, 1'b0, '0);
      end
    end

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == OP_CFG) begin
        settle();
        program_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        rq.kind = (dir_tab[i].op == OP_LOAD) ? REQ_LOAD : REQ_RENDER;
        rq.addr = dir_tab[i].addr;
        rq.data = dir_tab[i].data;
        rq.code = dir_tab[i].code;
        rq.attr = dir_tab[i].attr;
        rq.crow = dir_tab[i].crow;
        rq.ccol = dir_tab[i].ccol;
        issue(rq, 0, dir_tab[i].typed, dir_tab[i].typed_pix);
      end
    end

    foreach (idle_plan[p]) begin
      settle();
      shuffle_config();
      run_phase(idle_plan[p], 6);
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    for (int w = 0; w < 400 && pending_rows.size() != 0; w++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_rows.size() != 0) begin
      note_mismatch("rows still owed at the end", 64'(pending_rows.size()), '0);
    end

    $display("Sent %0d requests: %0d font loads and %0d cell renders, %0d rows checked.",
             n_loads + n_renders, n_loads, n_renders, n_rows);
    $display("Covered blink, cursor and idle-gap mixes over %0d random register settings.",
             n_settings);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
